/* sv/upes_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package upes_pkg;

	// Port table geometry
	localparam int NUM_PORTS = 256;
	localparam int PW        = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;

	// Waiting-port scan: one group of GRP_W flags per cycle
	localparam int GRP_W   = 8;
	localparam int GBW     = $clog2(GRP_W);
	localparam int NUM_GRP = (NUM_PORTS + GRP_W - 1) / GRP_W;
	localparam int GW      = (NUM_GRP > 1) ? $clog2(NUM_GRP) : 1;

	localparam logic [3:0] MAX_SPEED_RST = 4'd5;

	// Port configuration phases
	localparam logic [2:0] PH_NOTCONN    = 3'd0;
	localparam logic [2:0] PH_WAITING    = 3'd1;
	localparam logic [2:0] PH_RESETTING  = 3'd2;
	localparam logic [2:0] PH_ENSLOT     = 3'd3;
	localparam logic [2:0] PH_ADDRESSING = 3'd4;
	localparam logic [2:0] PH_INIT       = 3'd5;
	localparam logic [2:0] PH_CFGEP      = 3'd6;
	localparam logic [2:0] PH_CONFIGURED = 3'd7;

	// Status codes
	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_PHASE   = 3'd1;
	localparam logic [2:0] ST_SLOT    = 3'd2;
	localparam logic [2:0] ST_SPEED   = 3'd3;
	localparam logic [2:0] ST_DEVERR  = 3'd4;
	localparam logic [2:0] ST_NOTIMPL = 3'd5;

	// Event kinds
	localparam logic [2:0] FN_PORT_CHANGE = 3'd0;
	localparam logic [2:0] FN_CONFIGURE   = 3'd1;
	localparam logic [2:0] FN_CMD_DONE    = 3'd2;
	localparam logic [2:0] FN_XFER        = 3'd3;

	// Completed command types
	localparam logic [2:0] CT_ENSLOT = 3'd0;
	localparam logic [2:0] CT_ADDR   = 3'd1;
	localparam logic [2:0] CT_CFGEP  = 3'd2;
	localparam logic [2:0] CT_EVAL   = 3'd3;

	// Issued commands
	localparam logic [2:0] CM_NONE   = 3'd0;
	localparam logic [2:0] CM_ENSLOT = 3'd1;
	localparam logic [2:0] CM_ADDR   = 3'd2;
	localparam logic [2:0] CM_CFGEP  = 3'd3;
	localparam logic [2:0] CM_EVAL   = 3'd4;

	// Notifications
	localparam logic [1:0] NT_NONE  = 2'd0;
	localparam logic [1:0] NT_INIT  = 2'd1;
	localparam logic [1:0] NT_EPCFG = 2'd2;
	localparam logic [1:0] NT_EVAL  = 2'd3;

	// Controller to datapath strobes
	typedef struct packed {
		logic cap;   // capture input item
		logic rd;    // read table at event or lock port
		logic exec;  // evaluate event, write table, stage result
		logic scan;  // examine one group of waiting flags
		logic rd2;   // read table at found waiting port
		logic wr2;   // reset found waiting port if connected
		logic load;  // move staged result to output register
	} upes_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic scan_req;   // address completion needs a waiting-port search
		logic scan_hit;   // current group holds a waiting port
		logic scan_last;  // current group is the last one
		logic out_free;   // output register can take a result
	} upes_sts_t;

endpackage

`default_nettype wire

/* sv/usb_port_enumeration_sequencer.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake              Payload
// -------   ---------------------  -------------------------------------------------
// in        in_valid / in_ready    func port slot port_flags device_flags cmd_type
//                                  command_success speed_id
// out       out_valid / out_ready  status reset_request reset_port clear_reset_change
//                                  command command_slot command_port notify
// cfg       cfg_we (no wait)       cfg_wdata = max_speed_id
//
// An item passes through capture, port table read, evaluate and deliver. An
// address-device completion adds a search of the waiting-port flags, 8 ports
// per cycle, and a read and reset of the waiting port it finds. Reset clears
// the lock, the per-port valid and waiting flags and the output valid flag; no
// clearing pass is needed. A held output blocks only the final hand-over of
// the next item; capture and evaluation go on meanwhile.

module usb_port_enumeration_sequencer (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        cfg_we,
	input  wire  [3:0] cfg_wdata,
	input  wire        in_valid,
	output logic       in_ready,
	input  wire  [2:0] func,
	input  wire  [7:0] port,
	input  wire  [7:0] slot,
	input  wire  [2:0] port_flags,
	input  wire  [3:0] device_flags,
	input  wire  [2:0] cmd_type,
	input  wire        command_success,
	input  wire  [3:0] speed_id,
	output logic       out_valid,
	input  wire        out_ready,
	output logic [2:0] status,
	output logic       reset_request,
	output logic [7:0] reset_port,
	output logic       clear_reset_change,
	output logic [2:0] command,
	output logic [7:0] command_slot,
	output logic [7:0] command_port,
	output logic [1:0] notify
);
	import upes_pkg::*;

	upes_cmd_t cmd;
	upes_sts_t sts;

	// Sequence each item: capture, read, evaluate, optional search, deliver
	upes_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Hold port table, lock, speed limit and the result registers
	upes_dp u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.sts                (sts),
		.cfg_we             (cfg_we),
		.cfg_wdata          (cfg_wdata),
		.func               (func),
		.port               (port),
		.slot               (slot),
		.port_flags         (port_flags),
		.device_flags       (device_flags),
		.cmd_type           (cmd_type),
		.command_success    (command_success),
		.speed_id           (speed_id),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.status             (status),
		.reset_request      (reset_request),
		.reset_port         (reset_port),
		.clear_reset_change (clear_reset_change),
		.command            (command),
		.command_slot       (command_slot),
		.command_port       (command_port),
		.notify             (notify)
	);

endmodule

`default_nettype wire

/* sv/upes_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module upes_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_ready,
	input  upes_pkg::upes_sts_t  sts,
	output upes_pkg::upes_cmd_t  cmd
);
	import upes_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_RD   = 7'b0000010,
		S_EXEC = 7'b0000100,
		S_SCAN = 7'b0001000,
		S_RD2  = 7'b0010000,
		S_WR2  = 7'b0100000,
		S_DONE = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.cap = 1'b1;
					state_d = S_RD;
				end
			end
			S_RD: begin
				cmd.rd  = 1'b1;
				state_d = S_EXEC;
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = sts.scan_req ? S_SCAN : S_DONE;
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_hit) begin
					state_d = S_RD2;
				end else if (sts.scan_last) begin
					state_d = S_DONE;
				end
			end
			S_RD2: begin
				cmd.rd2 = 1'b1;
				state_d = S_WR2;
			end
			S_WR2: begin
				cmd.wr2 = 1'b1;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// An exhausted search must end the item instead of wrapping around
	ap_scan_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && sts.scan_last && !sts.scan_hit) |=> (state_q == S_DONE))
		else $error("waiting-port scan did not stop after last group");

endmodule

`default_nettype wire

/* sv/upes_dp.sv */
`timescale 1ns / 1ps
`default_nettype none

module upes_dp (
	input  wire                  clk,
	input  wire                  arst_n,
	input  upes_pkg::upes_cmd_t  cmd,
	output upes_pkg::upes_sts_t  sts,
	input  wire                  cfg_we,
	input  wire  [3:0]           cfg_wdata,
	input  wire  [2:0]           func,
	input  wire  [7:0]           port,
	input  wire  [7:0]           slot,
	input  wire  [2:0]           port_flags,
	input  wire  [3:0]           device_flags,
	input  wire  [2:0]           cmd_type,
	input  wire                  command_success,
	input  wire  [3:0]           speed_id,
	output logic                 out_valid,
	input  wire                  out_ready,
	output logic [2:0]           status,
	output logic                 reset_request,
	output logic [7:0]           reset_port,
	output logic                 clear_reset_change,
	output logic [2:0]           command,
	output logic [7:0]           command_slot,
	output logic [7:0]           command_port,
	output logic [1:0]           notify
);
	import upes_pkg::*;

	// Captured item
	logic [2:0] func_q;
	logic [7:0] port_q;
	logic [7:0] slot_q;
	logic [2:0] pflags_q;
	logic [3:0] dflags_q;
	logic [2:0] ctype_q;
	logic       ok_q;
	logic [3:0] speed_q;

	// Control state
	logic [3:0]                 max_speed_q;
	logic [7:0]                 active_q;
	logic [NUM_PORTS-1:0]       vld_q;
	logic [NUM_GRP*GRP_W-1:0]   waiting_q;
	logic [GW-1:0]              grp_q;
	logic                       out_valid_q;

	// Port table: {phase, connected}
	logic [3:0]    mem [NUM_PORTS];
	logic [3:0]    rd_q;
	logic          rd_vld_q;
	logic [PW-1:0] fnd_q;

	// Staged and delivered result
	logic [2:0] res_status_q, out_status_q;
	logic       res_rr_q, out_rr_q;
	logic [7:0] res_rport_q, out_rport_q;
	logic       res_clr_q, out_clr_q;
	logic [2:0] res_cmd_q, out_cmd_q;
	logic [7:0] res_cslot_q, out_cslot_q;
	logic [7:0] res_cport_q, out_cport_q;
	logic [1:0] res_notify_q, out_notify_q;

	logic [PW-1:0] idx_p, idx_a, ra, wa;
	logic [2:0]    ent_ph;
	logic          ent_conn;
	logic          p_ok;
	logic          we;
	logic [3:0]    wd;

	// Event evaluation results
	logic [2:0]    x_status;
	logic          x_rr;
	logic [7:0]    x_rport;
	logic          x_clr;
	logic [2:0]    x_cmd;
	logic [7:0]    x_cslot;
	logic [7:0]    x_cport;
	logic [1:0]    x_notify;
	logic          x_we;
	logic [PW-1:0] x_wa;
	logic [2:0]    x_wph;
	logic          x_wconn;
	logic          x_act_we;
	logic [7:0]    x_act_d;
	logic          x_scan;

	logic [GRP_W-1:0] grp;
	logic [GBW-1:0]   prio;

	assign idx_p    = port_q[PW-1:0];
	assign idx_a    = active_q[PW-1:0];
	assign p_ok     = (int'(port_q) < NUM_PORTS);
	assign ent_ph   = rd_vld_q ? rd_q[3:1] : PH_NOTCONN;
	assign ent_conn = rd_vld_q & rd_q[0];

	// Enable-slot completion concerns the lock holder, the second read the found waiting port, all else the event port
	assign ra = cmd.rd2 ? fnd_q :
		((func_q == FN_CMD_DONE && ctype_q == CT_ENSLOT) ? idx_a : idx_p);

	always_comb begin
		x_status = ST_OK;
		x_rr     = 1'b0;
		x_rport  = '0;
		x_clr    = 1'b0;
		x_cmd    = CM_NONE;
		x_cslot  = '0;
		x_cport  = '0;
		x_notify = NT_NONE;
		x_we     = 1'b0;
		x_wa     = idx_p;
		x_wph    = ent_ph;
		x_wconn  = ent_conn;
		x_act_we = 1'b0;
		x_act_d  = '0;
		x_scan   = 1'b0;
		case (func_q)
			FN_PORT_CHANGE, FN_CONFIGURE: begin
				if (!p_ok) begin
					x_status = ST_PHASE;
				end else begin
					x_we    = 1'b1;
					x_wconn = pflags_q[0];
					if (ent_ph == PH_NOTCONN) begin
						// A connected port takes the lock if free, else the port is queued
						if (pflags_q[0]) begin
							if (active_q != '0) begin
								x_wph = PH_WAITING;
							end else begin
								x_wph    = PH_RESETTING;
								x_act_we = 1'b1;
								x_act_d  = 8'(idx_p);
								x_rr     = 1'b1;
								x_rport  = 8'(idx_p);
							end
						end
					end else if (func_q == FN_PORT_CHANGE) begin
						case (ent_ph)
							PH_RESETTING: begin
								if (pflags_q[1] && pflags_q[2]) begin
									x_clr   = 1'b1;
									x_wph   = PH_ENSLOT;
									x_cmd   = CM_ENSLOT;
									x_cport = port_q;
								end
							end
							PH_WAITING, PH_ENSLOT, PH_CONFIGURED: begin
								x_status = ST_OK;
							end
							default: begin
								x_status = ST_PHASE;
							end
						endcase
					end
				end
			end
			FN_CMD_DONE: begin
				case (ctype_q)
					CT_ENSLOT: begin
						x_wa = idx_a;
						if (ent_ph != PH_ENSLOT) begin
							x_status = ST_PHASE;
						end else if (!dflags_q[0]) begin
							x_status = ST_SLOT;
						end else begin
							x_we    = 1'b1;
							x_wph   = PH_ADDRESSING;
							x_cmd   = CM_ADDR;
							x_cslot = slot_q;
							x_cport = active_q;
						end
					end
					CT_ADDR, CT_CFGEP, CT_EVAL: begin
						if (!dflags_q[0]) begin
							x_status = ST_SLOT;
						end else if (ctype_q == CT_EVAL) begin
							if (!ok_q) begin
								x_status = ST_PHASE;
							end else begin
								x_notify = NT_EVAL;
							end
						end else if (!p_ok) begin
							x_status = ST_PHASE;
						end else if (ctype_q == CT_CFGEP) begin
							if (ent_ph != PH_CFGEP) begin
								x_status = ST_PHASE;
							end else begin
								x_we     = 1'b1;
								x_wph    = PH_CONFIGURED;
								x_notify = NT_EPCFG;
							end
						end else if (port_q != active_q || ent_ph != PH_ADDRESSING) begin
							x_status = ST_PHASE;
						end else begin
							// Release the lock; the search for a waiting port follows
							x_we     = 1'b1;
							x_wph    = PH_INIT;
							x_act_we = 1'b1;
							x_act_d  = '0;
							x_notify = NT_INIT;
							x_scan   = 1'b1;
						end
					end
					default: begin
						x_status = ST_PHASE;
					end
				endcase
			end
			FN_XFER: begin
				if (!dflags_q[0]) begin
					x_status = ST_SLOT;
				end else if (dflags_q[3]) begin
					x_status = ST_DEVERR;
				end else if (!p_ok) begin
					x_status = ST_PHASE;
				end else if (ent_ph == PH_INIT) begin
					if (dflags_q[1]) begin
						if (speed_q == 4'd0 || speed_q > max_speed_q) begin
							x_status = ST_SPEED;
						end else begin
							x_we    = 1'b1;
							x_wph   = PH_CFGEP;
							x_cmd   = CM_CFGEP;
							x_cslot = slot_q;
							x_cport = port_q;
						end
					end else if (dflags_q[2]) begin
						x_cmd   = CM_EVAL;
						x_cslot = slot_q;
						x_cport = port_q;
					end
				end
			end
			default: begin
				x_status = ST_NOTIMPL;
			end
		endcase
	end

	// Lowest waiting flag in the current group
	assign grp = waiting_q[int'(grp_q)*GRP_W +: GRP_W];

	always_comb begin
		prio = '0;
		for (int i = GRP_W - 1; i >= 0; i--) begin
			if (grp[i]) begin
				prio = GBW'(i);
			end
		end
	end

	assign sts.scan_req  = x_scan;
	assign sts.scan_hit  = |grp;
	assign sts.scan_last = (grp_q == GW'(NUM_GRP - 1));
	assign sts.out_free  = !out_valid_q || out_ready;

	// Table write port
	assign we = (cmd.exec && x_we) || (cmd.wr2 && ent_conn);
	assign wa = cmd.wr2 ? fnd_q : x_wa;
	assign wd = cmd.wr2 ? {PH_RESETTING, 1'b1} : {x_wph, x_wconn};

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (cmd.rd || cmd.rd2) begin
			rd_q <= mem[ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_speed_q <= MAX_SPEED_RST;
			active_q    <= '0;
			vld_q       <= '0;
			waiting_q   <= '0;
			grp_q       <= '0;
			rd_vld_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				max_speed_q <= cfg_wdata;
			end
			if (cmd.exec && x_act_we) begin
				active_q <= x_act_d;
			end else if (cmd.wr2 && ent_conn) begin
				active_q <= 8'(fnd_q);
			end
			if (we) begin
				vld_q[wa]     <= 1'b1;
				waiting_q[wa] <= (wd[3:1] == PH_WAITING);
			end
			if (cmd.rd || cmd.rd2) begin
				rd_vld_q <= vld_q[ra];
			end
			if (cmd.exec) begin
				grp_q <= '0;
			end else if (cmd.scan && !sts.scan_hit && !sts.scan_last) begin
				grp_q <= grp_q + GW'(1);
			end
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			func_q   <= func;
			port_q   <= port;
			slot_q   <= slot;
			pflags_q <= port_flags;
			dflags_q <= device_flags;
			ctype_q  <= cmd_type;
			ok_q     <= command_success;
			speed_q  <= speed_id;
		end
		if (cmd.scan && sts.scan_hit) begin
			fnd_q <= PW'(int'(grp_q) * GRP_W + int'(prio));
		end
		if (cmd.exec) begin
			res_status_q <= x_status;
			res_rr_q     <= x_rr;
			res_rport_q  <= x_rport;
			res_clr_q    <= x_clr;
			res_cmd_q    <= x_cmd;
			res_cslot_q  <= x_cslot;
			res_cport_q  <= x_cport;
			res_notify_q <= x_notify;
		end else if (cmd.wr2 && ent_conn) begin
			res_rr_q    <= 1'b1;
			res_rport_q <= 8'(fnd_q);
		end
		if (cmd.load) begin
			out_status_q <= res_status_q;
			out_rr_q     <= res_rr_q;
			out_rport_q  <= res_rport_q;
			out_clr_q    <= res_clr_q;
			out_cmd_q    <= res_cmd_q;
			out_cslot_q  <= res_cslot_q;
			out_cport_q  <= res_cport_q;
			out_notify_q <= res_notify_q;
		end
	end

	assign out_valid          = out_valid_q;
	assign status             = out_status_q;
	assign reset_request      = out_rr_q;
	assign reset_port         = out_rport_q;
	assign clear_reset_change = out_clr_q;
	assign command            = out_cmd_q;
	assign command_slot       = out_cslot_q;
	assign command_port       = out_cport_q;
	assign notify             = out_notify_q;

	// The waiting flags must agree with the table
	ap_flag_coherent: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr2 |-> (rd_vld_q && rd_q[3:1] == PH_WAITING))
		else $error("waiting flag set for a port that is not waiting");

	// A reset request always goes to the port that now holds the lock
	ap_lock_owner: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load && res_rr_q) |-> (active_q == res_rport_q))
		else $error("reset issued to a port that does not hold the lock");

	// The lock is only taken while free
	ap_lock_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && x_rr) |-> (active_q == '0))
		else $error("lock taken while held");

endmodule

`default_nettype wire
